// ----- rtl/core/cbm_pkg.sv -----
// Package for the cartridge bank mapper: shared types, operation codes and constants.
// Used by every module in rtl/core; depends on nothing.
package cbm_pkg;

    localparam int CHR_SLOTS    = 8;
    localparam int SLOT_W       = $clog2(CHR_SLOTS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int PRG_W        = 18;
    localparam int CHR_W        = 19;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int IDX_W        = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 19;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;

    // Input function codes.
    localparam logic [1:0] FUNC_CPU_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CPU_READ  = 2'd1;
    localparam logic [1:0] FUNC_CHR_READ  = 2'd2;

    // Result targets.
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_SOUND   = 3'd4;
    localparam logic [2:0] TGT_IRQ     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_BANK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_LINES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN   = 3'd5;

    // Character banking modes.
    localparam logic [1:0] CHR_MODE_1K    = 2'd0;
    localparam logic [1:0] CHR_MODE_2K    = 2'd1;
    localparam logic [1:0] CHR_MODE_MIXED = 2'd2;

    // Mirroring codes.
    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

    // Register decode: upper nibble of the masked address.
    localparam logic [3:0] HI_WIN0  = 4'h8;
    localparam logic [3:0] HI_SND_A = 4'h9;
    localparam logic [3:0] HI_SND_B = 4'hA;
    localparam logic [3:0] HI_SND_C = 4'hB;
    localparam logic [3:0] HI_WIN1  = 4'hC;
    localparam logic [3:0] HI_CHR_L = 4'hD;
    localparam logic [3:0] HI_CHR_H = 4'hE;
    localparam logic [3:0] HI_IRQ   = 4'hF;
    localparam logic [1:0] LO_MODE  = 2'd3;

    // Classified operations handed from the front end to the back end.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RAM,
        OP_WIN0,
        OP_WIN1,
        OP_CHR_BANK,
        OP_MODE,
        OP_SOUND,
        OP_IRQ,
        OP_PRG_READ,
        OP_CHR_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  idx;
    } t_item;

    typedef struct packed {
        logic [PRG_W-1:0] prg_size_mask;
        logic [PRG_W-1:0] last_bank_offset;
        logic [CHR_W-1:0] chr_size_mask;
        logic             swap_low_lines;
        logic             prg_ram_present;
        logic             four_screen;
    } t_cfg;

    typedef struct packed {
        logic [2:0]       target;
        logic [CHR_W-1:0] mem_offset;
        logic [IDX_W-1:0] forward_index;
        logic [DATA_W-1:0] forward_data;
        logic [1:0]       mirroring;
    } t_result;

endpackage

// ----- rtl/core/cbm_front.sv -----
// Front end of the cartridge bank mapper: decodes each bus access into an operation.
// Depends on cbm_pkg.
module cbm_front
    import cbm_pkg::*;
(
    input  logic [1:0]        i_func,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_data,
    input  t_cfg              i_cfg,
    output t_item             o_item
);

    logic [ADDR_W-1:0] w_reg_addr;
    logic [3:0]        w_hi;
    logic [1:0]        w_lo;
    logic              w_ram_window;
    t_op               w_reg_op;
    logic [IDX_W-1:0]  w_reg_idx;

    assign w_ram_window = (i_addr[15:13] == 3'b011);

    // Optional swap of A0 and A1, then mask with 0xF003.
    always_comb begin
        w_reg_addr = {i_addr[15:12], 10'b0, i_addr[1:0]};
        if (i_cfg.swap_low_lines) begin
            w_reg_addr = {i_addr[15:12], 10'b0, i_addr[0], i_addr[1]};
        end
    end

    assign w_hi = w_reg_addr[15:12];
    assign w_lo = w_reg_addr[1:0];

    always_comb begin
        w_reg_op  = OP_NONE;
        w_reg_idx = '0;
        unique case (w_hi)
            HI_WIN0: w_reg_op = OP_WIN0;
            HI_WIN1: w_reg_op = OP_WIN1;
            HI_CHR_L: begin
                w_reg_op  = OP_CHR_BANK;
                w_reg_idx = {2'b00, w_lo};
            end
            HI_CHR_H: begin
                w_reg_op  = OP_CHR_BANK;
                w_reg_idx = {2'b01, w_lo};
            end
            HI_SND_A: begin
                w_reg_op  = OP_SOUND;
                w_reg_idx = {2'b00, w_lo};
            end
            HI_SND_B: begin
                if (w_lo != LO_MODE) begin
                    w_reg_op  = OP_SOUND;
                    w_reg_idx = IDX_W'(4) + {2'b00, w_lo};
                end
            end
            HI_SND_C: begin
                if (w_lo == LO_MODE) begin
                    w_reg_op = OP_MODE;
                end else begin
                    w_reg_op  = OP_SOUND;
                    w_reg_idx = IDX_W'(7) + {2'b00, w_lo};
                end
            end
            HI_IRQ: begin
                if (w_lo != LO_MODE) begin
                    w_reg_op  = OP_IRQ;
                    w_reg_idx = {2'b00, w_lo};
                end
            end
            default: w_reg_op = OP_NONE;
        endcase
    end

    always_comb begin
        o_item.op   = OP_NONE;
        o_item.addr = i_addr;
        o_item.data = i_data;
        o_item.idx  = '0;
        unique case (i_func)
            FUNC_CPU_WRITE: begin
                if (w_ram_window) begin
                    if (i_cfg.prg_ram_present) o_item.op = OP_RAM;
                end else if (i_addr[15]) begin
                    o_item.op  = w_reg_op;
                    o_item.idx = w_reg_idx;
                end
            end
            FUNC_CPU_READ: begin
                if (w_ram_window) begin
                    if (i_cfg.prg_ram_present) o_item.op = OP_RAM;
                end else if (i_addr[15]) begin
                    o_item.op = OP_PRG_READ;
                end
            end
            FUNC_CHR_READ: o_item.op = OP_CHR_READ;
            default:       o_item.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/core/cbm_queue.sv -----
// Short queue between the front end and the back end of the bank mapper.
// Depends on cbm_pkg.
module cbm_queue
    import cbm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/core/cbm_back.sv -----
// Back end of the bank mapper: holds bank state, applies writes, translates reads.
// Registers one result at a time toward the output. Depends on cbm_pkg.
module cbm_back
    import cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [PRG_W-1:0]  r_win0;
    logic [PRG_W-1:0]  r_win1;
    logic [DATA_W-1:0] r_chr_bank [CHR_SLOTS];
    logic [1:0]        r_chr_mode;
    logic [1:0]        r_mirror;
    logic              r_out_valid;
    t_result           r_result;

    logic [1:0]        n_chr_mode;
    logic [1:0]        n_mirror;
    t_result           n_result;

    logic [PRG_W-1:0]  w_prg_base;
    logic [PRG_W-1:0]  w_prg_low;
    logic [PRG_W-1:0]  w_prg_sum;
    logic [SLOT_W-1:0] w_slot;
    logic              w_wide_slot;
    logic [SLOT_W-1:0] w_bank_idx;
    logic [DATA_W-1:0] w_bank;
    logic [CHR_W-1:0]  w_chr_base;
    logic [CHR_W-1:0]  w_chr_sum;

    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // Program ROM window selection.
    always_comb begin
        if (!i_item.addr[14]) begin
            w_prg_base = r_win0;
            w_prg_low  = PRG_W'(i_item.addr[13:0]);
        end else if (!i_item.addr[13]) begin
            w_prg_base = r_win1;
            w_prg_low  = PRG_W'(i_item.addr[12:0]);
        end else begin
            w_prg_base = i_cfg.last_bank_offset;
            w_prg_low  = PRG_W'(i_item.addr[12:0]);
        end
    end
    assign w_prg_sum = (w_prg_base + w_prg_low) & i_cfg.prg_size_mask;

    // Character translation: 2K banks in mode 1, and for the upper half in mixed mode.
    assign w_slot      = i_item.addr[12:10];
    assign w_wide_slot = (r_chr_mode == CHR_MODE_2K) ||
                         ((r_chr_mode == CHR_MODE_MIXED) && w_slot[SLOT_W-1]);
    always_comb begin
        if (!w_wide_slot) begin
            w_bank_idx = w_slot;
        end else if (r_chr_mode == CHR_MODE_2K) begin
            w_bank_idx = {1'b0, w_slot[SLOT_W-1:1]};
        end else begin
            w_bank_idx = {1'b0, w_slot[SLOT_W-1:1]} + SLOT_W'(2);
        end
    end
    assign w_bank     = r_chr_bank[w_bank_idx];
    assign w_chr_base = w_wide_slot ? {w_bank, w_slot[0], 10'b0} : {1'b0, w_bank, 10'b0};
    assign w_chr_sum  = (w_chr_base + CHR_W'(i_item.addr[9:0])) & i_cfg.chr_size_mask;

    // Mode register: character mode always, mirroring only for listed codes without four-screen.
    always_comb begin
        n_chr_mode = (i_item.data[1:0] == 2'd3) ? CHR_MODE_MIXED : i_item.data[1:0];
        n_mirror   = r_mirror;
        if (!i_cfg.four_screen) begin
            case (i_item.data[3:0])
                4'h0, 4'h7: n_mirror = MIR_VERTICAL;
                4'h3, 4'h4: n_mirror = MIR_HORIZONTAL;
                4'h8, 4'hF: n_mirror = MIR_SINGLE_LO;
                4'hB, 4'hC: n_mirror = MIR_SINGLE_HI;
                default:    n_mirror = r_mirror;
            endcase
        end
    end

    always_comb begin
        n_result.target        = TGT_NONE;
        n_result.mem_offset    = '0;
        n_result.forward_index = '0;
        n_result.forward_data  = '0;
        n_result.mirroring     = r_mirror;
        unique case (i_item.op)
            OP_RAM: begin
                n_result.target     = TGT_PRG_RAM;
                n_result.mem_offset = CHR_W'(i_item.addr[12:0]);
            end
            OP_PRG_READ: begin
                n_result.target     = TGT_PRG_ROM;
                n_result.mem_offset = CHR_W'(w_prg_sum);
            end
            OP_CHR_READ: begin
                n_result.target     = TGT_CHR_ROM;
                n_result.mem_offset = w_chr_sum;
            end
            OP_SOUND: begin
                n_result.target        = TGT_SOUND;
                n_result.forward_index = i_item.idx;
                n_result.forward_data  = i_item.data;
            end
            OP_IRQ: begin
                n_result.target        = TGT_IRQ;
                n_result.forward_index = i_item.idx;
                n_result.forward_data  = i_item.data;
            end
            OP_MODE: n_result.mirroring = n_mirror;
            default: n_result.target = TGT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0      <= '0;
            r_win1      <= PRG_W'(18'h04000);
            r_chr_bank  <= '{default: '0};
            r_chr_mode  <= CHR_MODE_1K;
            r_mirror    <= MIR_VERTICAL;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                unique case (i_item.op)
                    OP_WIN0:     r_win0 <= {i_item.data[3:0], 14'b0} & i_cfg.prg_size_mask;
                    OP_WIN1:     r_win1 <= {i_item.data[4:0], 13'b0} & i_cfg.prg_size_mask;
                    OP_CHR_BANK: r_chr_bank[i_item.idx[SLOT_W-1:0]] <= i_item.data;
                    OP_MODE: begin
                        r_chr_mode <= n_chr_mode;
                        r_mirror   <= n_mirror;
                    end
                    default: ;
                endcase
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.target <= TGT_IRQ))
        else $error("result target out of range");

    a_locked_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.op == OP_MODE && i_cfg.four_screen) |=> $stable(r_mirror))
        else $error("mirroring changed while locked");

    a_chr_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chr_mode != 2'd3)
        else $error("character mode holds an unused code");

endmodule

// ----- rtl/core/cartridge_bank_mapper_top.sv -----
// An accepted bus access is registered in the queue, then its result in the output register.
// Throughput: one access per cycle while the output is ready; the decoder, a two-entry
// queue and the single output register each pass one item per cycle.
// Reset (synchronous, active low) restores the bank state and the configuration
// registers to their defaults and empties the queue and the output register.
// Top level of the cartridge bank mapper; depends on cbm_pkg, cbm_front, cbm_queue, cbm_back.
module cartridge_bank_mapper_top
    import cbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Bus access input.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // bus_address[15:0], write_data[23:16]
    input  logic [1:0]             i_s_axis_tuser,  // func[1:0]
    // Result output.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // mem_offset[18:0], forward_index[22:19],
                                                    // forward_data[30:23], mirroring[32:31]
    output logic [2:0]             o_m_axis_tuser   // target[2:0]
);

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_q_item;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_pop;
    logic    w_push;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_size_mask    <= PRG_W'(18'h3FFFF);
            r_cfg.last_bank_offset <= PRG_W'(18'h3E000);
            r_cfg.chr_size_mask    <= CHR_W'(19'h7FFFF);
            r_cfg.swap_low_lines   <= 1'b0;
            r_cfg.prg_ram_present  <= 1'b1;
            r_cfg.four_screen      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRG_SIZE_MASK: r_cfg.prg_size_mask    <= i_cfg_data[PRG_W-1:0];
                CFG_LAST_BANK:     r_cfg.last_bank_offset <= i_cfg_data[PRG_W-1:0];
                CFG_CHR_SIZE_MASK: r_cfg.chr_size_mask    <= i_cfg_data;
                CFG_SWAP_LINES:    r_cfg.swap_low_lines   <= i_cfg_data[0];
                CFG_PRG_RAM:       r_cfg.prg_ram_present  <= i_cfg_data[0];
                CFG_FOUR_SCREEN:   r_cfg.four_screen      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !w_q_full;
    assign w_push          = i_s_axis_tvalid && !w_q_full;

    cbm_front u_front (
        .i_func (i_s_axis_tuser),
        .i_addr (i_s_axis_tdata[15:0]),
        .i_data (i_s_axis_tdata[23:16]),
        .i_cfg  (r_cfg),
        .o_item (w_front_item)
    );

    cbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    cbm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (w_result)
    );

    assign o_m_axis_tuser = w_result.target;
    assign o_m_axis_tdata = {7'b0, w_result.mirroring, w_result.forward_data,
                             w_result.forward_index, w_result.mem_offset};

endmodule

// ----- tb/cartridge_bank_mapper_top_test.sv -----
// Self-checking testbench for cartridge_bank_mapper_top: bus accesses in, one translated result out.
// Depends on cbm_pkg and the mapper RTL; a bit-exact bank-state predictor lives in this module.
module cartridge_bank_mapper_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam logic [1:0]        FUNC_UNUSED  = 2'd3;
    localparam logic [ADDR_W-1:0] RAM_START    = 16'h6000;
    localparam logic [ADDR_W-1:0] ROM_START    = 16'h8000;
    localparam logic [ADDR_W-1:0] WIN1_START   = 16'hC000;
    localparam logic [ADDR_W-1:0] FIXED_START  = 16'hE000;
    localparam logic [ADDR_W-1:0] MODE_REG     = 16'hB003;
    localparam logic [IDX_W-1:0]  SND_B_FIRST  = 4'd4;
    localparam logic [IDX_W-1:0]  SND_C_FIRST  = 4'd7;
    localparam int                HOLD_CYCLES  = 100;
    localparam int                STALL_LIMIT  = 2000;
    localparam int                DRAIN_CYCLES = 10;
    localparam int                PRINT_LIMIT  = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [2:0]             o_m_axis_tuser;

    // Predicted mapper configuration and bank state.
    logic [PRG_W-1:0] cfg_prg_mask;
    logic [PRG_W-1:0] cfg_last_bank;
    logic [CHR_W-1:0] cfg_chr_mask;
    logic             cfg_swap;
    logic             cfg_ram;
    logic             cfg_four;
    logic [PRG_W-1:0] win0_base;
    logic [PRG_W-1:0] win1_base;
    logic [7:0]       chr_banks [CHR_SLOTS];
    logic [1:0]       chr_mode;
    logic [1:0]       mirror;

    t_result expected_results[$];
    int      error_count = 0;
    int      accesses_sent = 0;
    int      results_checked = 0;
    int      configs_applied = 0;
    int      idle_cycles = 0;
    bit      src_idle_on = 1'b1;
    bit      sink_idle_on = 1'b1;
    bit      hold_request = 1'b0;

    cartridge_bank_mapper_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Advances the predicted bank state by one bus access and returns its result.
    function automatic t_result map_access(logic [1:0] fn, logic [ADDR_W-1:0] a,
                                           logic [DATA_W-1:0] d);
        t_result          r;
        logic [3:0]       hi;
        logic [1:0]       lo;
        logic [2:0]       slot;
        logic [2:0]       bank;
        logic [CHR_W-1:0] base;
        logic [PRG_W-1:0] sum;
        r = '0;
        hi = a[15:12];
        lo = cfg_swap ? {a[0], a[1]} : a[1:0];
        if (fn == FUNC_CPU_WRITE || fn == FUNC_CPU_READ) begin
            if (a >= RAM_START && a < ROM_START) begin
                if (cfg_ram) begin
                    r.target = TGT_PRG_RAM;
                    r.mem_offset = CHR_W'(a[12:0]);
                end
            end else if (a >= ROM_START && fn == FUNC_CPU_READ) begin
                if (a < WIN1_START) sum = win0_base + PRG_W'(a[13:0]);
                else if (a < FIXED_START) sum = win1_base + PRG_W'(a[12:0]);
                else sum = cfg_last_bank + PRG_W'(a[12:0]);
                r.target = TGT_PRG_ROM;
                r.mem_offset = CHR_W'(sum & cfg_prg_mask);
            end else if (a >= ROM_START) begin
                case (hi)
                    HI_WIN0:  win0_base = {d[3:0], 14'b0} & cfg_prg_mask;
                    HI_WIN1:  win1_base = {d[4:0], 13'b0} & cfg_prg_mask;
                    HI_CHR_L: chr_banks[{1'b0, lo}] = d;
                    HI_CHR_H: chr_banks[{1'b1, lo}] = d;
                    HI_SND_A: begin
                        r.target = TGT_SOUND;
                        r.forward_index = IDX_W'(lo);
                    end
                    HI_SND_B: begin
                        if (lo != LO_MODE) begin
                            r.target = TGT_SOUND;
                            r.forward_index = SND_B_FIRST + IDX_W'(lo);
                        end
                    end
                    HI_SND_C: begin
                        if (lo == LO_MODE) begin
                            chr_mode = (d[1:0] == 2'd3) ? CHR_MODE_MIXED : d[1:0];
                            // Codes outside the listed pairs leave mirroring alone.
                            if (!cfg_four) begin
                                case (d[3:0])
                                    4'h0, 4'h7: mirror = MIR_VERTICAL;
                                    4'h3, 4'h4: mirror = MIR_HORIZONTAL;
                                    4'h8, 4'hF: mirror = MIR_SINGLE_LO;
                                    4'hB, 4'hC: mirror = MIR_SINGLE_HI;
                                    default: ;
                                endcase
                            end
                        end else begin
                            r.target = TGT_SOUND;
                            r.forward_index = SND_C_FIRST + IDX_W'(lo);
                        end
                    end
                    HI_IRQ: begin
                        if (lo != LO_MODE) begin
                            r.target = TGT_IRQ;
                            r.forward_index = IDX_W'(lo);
                        end
                    end
                    default: ;
                endcase
                if (r.target == TGT_SOUND || r.target == TGT_IRQ) r.forward_data = d;
            end
        end else if (fn == FUNC_CHR_READ) begin
            slot = a[12:10];
            if (chr_mode == CHR_MODE_2K || (chr_mode == CHR_MODE_MIXED && slot[2])) begin
                bank = (chr_mode == CHR_MODE_2K) ? {1'b0, slot[2:1]} : {1'b0, slot[2:1]} + 3'd2;
                base = {chr_banks[bank], slot[0], 10'b0};
            end else begin
                base = {1'b0, chr_banks[slot], 10'b0};
            end
            r.target = TGT_CHR_ROM;
            r.mem_offset = (base | CHR_W'(a[9:0])) & cfg_chr_mask;
        end
        r.mirroring = mirror;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h (result %0d)",
                     $time, what, got, want, results_checked);
    endtask

    task automatic send_access(logic [1:0] fn, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        if (src_idle_on && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 35);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, a};
        s_tuser  <= fn;
        @(posedge clk);
        while (!o_s_axis_tready) @(posedge clk);
        expected_results.push_back(map_access(fn, a, d));
        accesses_sent++;
    endtask

    // Stops offering accesses and waits until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [PRG_W-1:0] prg_mask, last_bank,
                                  input logic [CHR_W-1:0] chr_mask,
                                  input logic swap, ram, four);
        drain_results();
        write_register(CFG_PRG_SIZE_MASK, CFG_DATA_W'(prg_mask));
        write_register(CFG_LAST_BANK, CFG_DATA_W'(last_bank));
        write_register(CFG_CHR_SIZE_MASK, CFG_DATA_W'(chr_mask));
        write_register(CFG_SWAP_LINES, CFG_DATA_W'(swap));
        write_register(CFG_PRG_RAM, CFG_DATA_W'(ram));
        write_register(CFG_FOUR_SCREEN, CFG_DATA_W'(four));
        cfg_valid <= 1'b0;
        cfg_prg_mask  = prg_mask;
        cfg_last_bank = last_bank;
        cfg_chr_mask  = chr_mask;
        cfg_swap      = swap;
        cfg_ram       = ram;
        cfg_four      = four;
        configs_applied++;
    endtask

    // Mostly register writes, mode writes and reads of every kind; a few raw accesses.
    task automatic run_random(int count);
        logic [1:0]        fn;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        int                pick;
        repeat (count) begin
            pick = $urandom_range(99);
            a = 16'($urandom);
            d = 8'($urandom);
            fn = FUNC_CPU_WRITE;
            if (pick < 30) a[15] = 1'b1;
            else if (pick < 40) a = MODE_REG;
            else if (pick < 58) fn = FUNC_CPU_READ;
            else if (pick < 83) fn = FUNC_CHR_READ;
            else if (pick < 93) begin
                a[15:13] = 3'b011;
                fn = (pick < 88) ? FUNC_CPU_WRITE : FUNC_CPU_READ;
            end else begin
                fn = 2'($urandom);
            end
            send_access(fn, a, d);
        end
    endtask

    task automatic test_directed_cases();
        send_access(FUNC_CPU_WRITE, 16'h0000, 8'h00);
        send_access(FUNC_CPU_READ, 16'h0000, 8'hFF);
        send_access(FUNC_CPU_WRITE, RAM_START, 8'hFF);
        send_access(FUNC_CPU_READ, 16'h7FFF, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h8000, 8'hFF);
        send_access(FUNC_CPU_WRITE, 16'hC003, 8'hFF);
        for (int i = 0; i < CHR_SLOTS; i++)
            send_access(FUNC_CPU_WRITE, (i < 4 ? 16'hD000 : 16'hE000) | 16'(i % 4),
                        8'(8'hF1 - 8'(i * 8'h23)));
        // Mixed character mode with single-screen upper, then an unlisted mirroring code.
        send_access(FUNC_CPU_WRITE, MODE_REG, 8'h0B);
        send_access(FUNC_CHR_READ, 16'h1FFF, 8'h00);
        send_access(FUNC_CPU_WRITE, MODE_REG, 8'hF1);
        send_access(FUNC_CHR_READ, 16'hFFFF, 8'h00);
        send_access(FUNC_CPU_READ, 16'hBFFF, 8'h00);
        send_access(FUNC_CPU_READ, WIN1_START, 8'h00);
        send_access(FUNC_CPU_READ, 16'hFFFF, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h9003, 8'hA5);
        send_access(FUNC_CPU_WRITE, 16'hA003, 8'h5A);
        send_access(FUNC_CPU_WRITE, 16'hB002, 8'h3C);
        send_access(FUNC_CPU_WRITE, 16'hF002, 8'hC3);
        send_access(FUNC_CPU_WRITE, 16'hF003, 8'hFF);
        send_access(FUNC_UNUSED, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_reset_defaults();
        run_random(150);
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_input_stall();
        src_idle_on = 1'b0;
        hold_request = 1'b1;
        run_random(40);
        src_idle_on = 1'b1;
        drain_results();
    endtask

    task automatic test_config_low_extremes();
        apply_settings('0, '0, '0, 1'b1, 1'b0, 1'b1);
        run_random(120);
    endtask

    task automatic test_config_high_extremes();
        apply_settings('1, '1, '1, 1'b0, 1'b1, 1'b0);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        run_random(200);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_config_typical();
        apply_settings(18'h1FFFF, 18'h1E000, 19'h3FFFF, 1'b1, 1'b1, 1'b0);
        run_random(150);
    endtask

    task automatic test_config_random();
        repeat (2) begin
            apply_settings(18'($urandom), 18'($urandom), 19'($urandom),
                           1'($urandom), 1'($urandom), 1'($urandom));
            run_random(130);
        end
    endtask

    task automatic test_four_screen_lock();
        apply_settings('1, 18'h3E000, '1, 1'b0, 1'b1, 1'b1);
        run_random(100);
    endtask

    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= !(sink_idle_on && $urandom_range(99) < 35);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, target", o_m_axis_tuser, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser !== want.target)
                    report_mismatch("target", o_m_axis_tuser, want.target);
                if (o_m_axis_tdata[18:0] !== want.mem_offset)
                    report_mismatch("mem_offset", o_m_axis_tdata[18:0], want.mem_offset);
                if (o_m_axis_tdata[22:19] !== want.forward_index)
                    report_mismatch("forward_index", o_m_axis_tdata[22:19], want.forward_index);
                if (o_m_axis_tdata[30:23] !== want.forward_data)
                    report_mismatch("forward_data", o_m_axis_tdata[30:23], want.forward_data);
                if (o_m_axis_tdata[32:31] !== want.mirroring)
                    report_mismatch("mirroring", o_m_axis_tdata[32:31], want.mirroring);
            end
            results_checked++;
        end
    end

    // Any transaction on any channel restarts the count.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : test_sequence
        cfg_prg_mask  = 18'h3FFFF;
        cfg_last_bank = 18'h3E000;
        cfg_chr_mask  = 19'h7FFFF;
        cfg_swap      = 1'b0;
        cfg_ram       = 1'b1;
        cfg_four      = 1'b0;
        win0_base     = '0;
        win1_base     = 18'h04000;
        chr_mode      = CHR_MODE_1K;
        mirror        = MIR_VERTICAL;
        for (int i = 0; i < CHR_SLOTS; i++) chr_banks[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_reset_defaults();
        test_input_stall();
        test_config_low_extremes();
        test_config_high_extremes();
        test_config_typical();
        test_config_random();
        test_four_screen_lock();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d bus accesses and %0d checked results across %0d mapper settings.",
                 accesses_sent, results_checked, configs_applied + 1);
        $display("Mismatches found: %0d", error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
